@@ hdl/move_to_front_rank_table_defines.svh @@
`ifndef MOVE_TO_FRONT_RANK_TABLE_DEFINES_SVH
`define MOVE_TO_FRONT_RANK_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MTFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("move_to_front_rank_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MTFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("move_to_front_rank_table: next-cycle check failed");

`endif

@@ hdl/mtfr_pkg.sv @@
package mtfr_pkg;

   localparam int COLOR_W = 7;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_BEFORE,
      ST_SWEEP,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;        // perform a load request this cycle
      logic capture;     // latch the color of a query request
      logic rd_query;    // read the queried color's entry
      logic take_before; // latch the read data as the old position
      logic sweep_rd;    // read the entry at the sweep counter and advance
      logic out_load;    // move the old position into the output register
   } cmd_type;

   typedef struct packed {
      logic color_ok;
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

@@ hdl/mtfr_ctrl.sv @@
`include "move_to_front_rank_table_defines.svh"

module mtfr_ctrl
   import mtfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == KIND_QUERY) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (status.color_ok) begin
               state_in = ST_BEFORE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BEFORE: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_tuser == KIND_LOAD);
            cmd.capture = accept && (req_tuser == KIND_QUERY);
         end
         ST_FETCH:  cmd.rd_query    = status.color_ok;
         ST_BEFORE: cmd.take_before = 1'b1;
         ST_SWEEP:  cmd.sweep_rd    = 1'b1;
         ST_FLUSH:  cmd = '0;
         ST_DONE:   cmd.out_load    = status.out_free;
         default:   cmd = '0;
      endcase
   end

   `MTFR_ASSERT_NOW(a_out_free, clock, reset, cmd.out_load, status.out_free)
   `MTFR_ASSERT_NEXT(a_sweep_end, clock, reset,
      (state_ff == ST_SWEEP) && status.sweep_last, state_ff == ST_FLUSH)
   `MTFR_ASSERT_NEXT(a_bad_color, clock, reset,
      (state_ff == ST_FETCH) && !status.color_ok, state_ff == ST_DONE)

endmodule

@@ hdl/mtfr_dp.sv @@
`include "move_to_front_rank_table_defines.svh"

module mtfr_dp
   import mtfr_pkg::*;
#(
   parameter int NUM_COLORS    = 64,
   parameter int POSITION_BITS = 16,
   parameter int TDATA_W       = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COLOR_W-1:0] req_color,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_COLORS - 1);

   logic [POSITION_BITS-1:0] mem [NUM_COLORS];
   logic [NUM_COLORS-1:0]    valid_ff;

   logic [POSITION_BITS-1:0] rd_data_ff;
   logic                     rd_vld_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     rd_en;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [POSITION_BITS-1:0] wr_data;

   logic [8:0]               color_x;
   logic                     color_ok;
   logic [IDX_W-1:0]         color_idx;

   logic [IDX_W-1:0]         idx_ff;
   logic                     ok_ff;
   logic [POSITION_BITS-1:0] before_ff;
   logic [POSITION_BITS-1:0] before_in;
   logic [POSITION_BITS-1:0] count_ff;
   logic [POSITION_BITS-1:0] count_in;
   logic [IDX_W-1:0]         sweep_ff;
   logic [IDX_W-1:0]         pend_addr_ff;
   logic                     pend_ff;
   logic [POSITION_BITS-1:0] entry;
   logic                     rsp_valid_ff;
   logic [POSITION_BITS-1:0] rsp_data_ff;
   logic                     out_free;

   assign color_x   = 9'(req_color);
   assign color_ok  = (color_x != 9'd0) && (color_x <= 9'(NUM_COLORS));
   assign color_idx = IDX_W'(color_x - 9'd1);

   assign entry    = rd_vld_ff ? rd_data_ff : '0;
   assign count_in = count_ff + POS_ONE;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign rd_en   = cmd.rd_query || cmd.sweep_rd;
   assign rd_addr = cmd.rd_query ? idx_ff : sweep_ff;

   // Sweep write-back lands in the cycle after its read; loads use the port when idle.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = entry + POS_ONE;
      if (pend_ff) begin
         if (pend_addr_ff == idx_ff) begin
            wr_en   = 1'b1;
            wr_data = POS_ONE;
         end else if (entry < before_ff) begin
            wr_en   = 1'b1;
         end
      end else if (cmd.load && count_ff != POS_MAX && color_ok && !valid_ff[color_idx]) begin
         wr_en   = 1'b1;
         wr_addr = color_idx;
         wr_data = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      before_in = before_ff;
      if (cmd.capture) begin
         before_in = '0;
      end else if (cmd.take_before) begin
         before_in = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.load && count_ff != POS_MAX) begin
            count_ff <= count_in;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
         pend_ff <= cmd.sweep_rd;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= color_idx;
         ok_ff  <= color_ok;
      end
      before_ff <= before_in;
      if (cmd.take_before) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_rd) begin
         sweep_ff <= sweep_ff + IDX_W'(1);
      end
      if (cmd.sweep_rd) begin
         pend_addr_ff <= sweep_ff;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= before_ff;
      end
   end

   assign status.color_ok   = ok_ff;
   assign status.sweep_last = (sweep_ff == IDX_LAST);
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

   `MTFR_ASSERT_NOW(a_one_writer, clock, reset, pend_ff, !cmd.load)
   `MTFR_ASSERT_NEXT(a_valid_set, clock, reset, wr_en, valid_ff[$past(wr_addr)])
   `MTFR_ASSERT_NEXT(a_count_mono, clock, reset, !reset, count_ff >= $past(count_ff))

endmodule

@@ hdl/move_to_front_rank_table.sv @@
// Channel  Ports                    Direction  Contents
// req      req_tvalid/tready/tdata  in         tuser = kind, tdata = color
//          req_tuser
// rsp      rsp_tvalid/tready/tdata  out        tdata = position (one per query)
//
// A load is accepted and, if its color is in range and new and the deck is not full,
// written to the table in the same cycle. A query does one table read for the old
// position, then a sweep over the two-port table memory, one entry read per cycle and
// written back if below the old position or queried; out of range skips the sweep.
// Reset is synchronous and clears the per-entry valid bits, so no clearing pass runs.
// A result held by rsp_tready low stalls only the end of the next query; loads go on.
module move_to_front_rank_table
   import mtfr_pkg::*;
#(
   parameter int NUM_COLORS    = 64,
   parameter int POSITION_BITS = 16,
   localparam int TDATA_W      = ((POSITION_BITS + 7) / 8) * 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [6:0] color, [7] zero
   input  logic               req_tuser,   // [0] kind
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // [POSITION_BITS-1:0] position, rest zero
);

   cmd_type    cmd;
   status_type status;

   mtfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mtfr_dp #(
      .NUM_COLORS    (NUM_COLORS),
      .POSITION_BITS (POSITION_BITS),
      .TDATA_W       (TDATA_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_color  (req_tdata[COLOR_W-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import mtfr_pkg::*;

   localparam int NUM_COLORS    = 64;
   localparam int POSITION_BITS = 16;
   localparam int SLOT_W        = $clog2(NUM_COLORS);
   localparam int TDATA_W       = ((POSITION_BITS + 7) / 8) * 8;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam int RANDOM_REQUESTS = 480;
   localparam int QUERY_CYCLES    = NUM_COLORS + 5;
   localparam int STALL_LIMIT     = 2000;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [7:0]         req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [TDATA_W-1:0] rsp_tdata;

   // Per-color top-card positions and deck counter, tracked request by request.
   class rank_scoreboard;
      logic [POSITION_BITS-1:0] rank [NUM_COLORS];
      logic [POSITION_BITS-1:0] deck_count;
      logic [POSITION_BITS-1:0] due_positions [$];
      int errors;
      int loads;
      int full_loads;
      int queries;
      int checked;

      function new();
         foreach (rank[j]) rank[j] = '0;
         deck_count = '0;
         errors     = 0;
         loads      = 0;
         full_loads = 0;
         queries    = 0;
         checked    = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("ERROR at %0t ns: %s", $time, what);
      endtask

      function void note_request(input logic kind, input logic [COLOR_W-1:0] color);
         logic [POSITION_BITS-1:0] old_pos;
         logic [SLOT_W-1:0]        slot;
         bit                       in_range;
         in_range = (color >= 1) && (color <= NUM_COLORS);
         slot     = SLOT_W'(color - 1);
         if (kind == KIND_LOAD) begin
            loads++;
            if (deck_count == POS_MAX) begin
               full_loads++;
            end else begin
               deck_count++;
               if (in_range && rank[slot] == '0) rank[slot] = deck_count;
            end
         end else begin
            queries++;
            old_pos = '0;
            if (in_range) begin
               old_pos = rank[slot];
               // bump every entry below the old position, absent ones too
               foreach (rank[j])
                  if (rank[j] < old_pos && rank[j] != POS_MAX) rank[j]++;
               rank[slot] = POSITION_BITS'(1);
            end
            due_positions.push_back(old_pos);
         end
      endfunction

      task check_position(input logic [TDATA_W-1:0] got);
         logic [POSITION_BITS-1:0] want;
         if (due_positions.size() == 0) begin
            report($sformatf("position %0d returned with no query outstanding", got));
         end else begin
            want = due_positions.pop_front();
            checked++;
            if (got !== TDATA_W'(want))
               report($sformatf("position %0d returned, %0d predicted", got, want));
         end
      endtask
   endclass

   rank_scoreboard book;
   int             idle_cycles = 0;
   bit             req_calm    = 0;
   bit             rsp_calm    = 0;

   move_to_front_rank_table #(
      .NUM_COLORS    (NUM_COLORS),
      .POSITION_BITS (POSITION_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Call at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input logic kind, input logic [COLOR_W-1:0] color);
      int gap;
      if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, color};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      book.note_request(kind, color);
      @(negedge clock);
   endtask

   function automatic logic [COLOR_W-1:0] random_color();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 16) return COLOR_W'($urandom_range(1, NUM_COLORS));
      else if (pick < 18) return '0;
      else return COLOR_W'($urandom_range(NUM_COLORS + 1, 127));
   endfunction

   // Result side: random stall before each result, hold ready until it arrives.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         book.check_position(rsp_tdata);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
         $display("move_to_front_rank_table: mismatch");
         $finish;
      end
   end

   initial begin
      logic             kind;
      logic [COLOR_W-1:0] color;
      book       = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_LOAD;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, out-of-range colors, repeats, the color extremes
      send_request(KIND_QUERY, 7'd5);
      send_request(KIND_LOAD,  7'd0);
      send_request(KIND_LOAD,  7'd64);
      send_request(KIND_LOAD,  7'd1);
      send_request(KIND_LOAD,  7'd127);
      send_request(KIND_LOAD,  7'd65);
      send_request(KIND_LOAD,  7'd64);
      send_request(KIND_LOAD,  7'd2);
      send_request(KIND_LOAD,  7'd33);
      send_request(KIND_QUERY, 7'd64);
      send_request(KIND_QUERY, 7'd0);
      send_request(KIND_QUERY, 7'd127);
      send_request(KIND_QUERY, 7'd65);
      send_request(KIND_QUERY, 7'd33);
      send_request(KIND_QUERY, 7'd33);
      send_request(KIND_QUERY, 7'd1);
      send_request(KIND_QUERY, 7'd10);
      send_request(KIND_LOAD,  7'd10);
      send_request(KIND_LOAD,  7'd3);
      send_request(KIND_QUERY, 7'd3);
      send_request(KIND_QUERY, 7'd64);
      send_request(KIND_QUERY, 7'd2);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         kind  = ($urandom_range(0, 9) < 4) ? KIND_QUERY : KIND_LOAD;
         color = random_color();
         send_request(kind, color);
      end
      req_tvalid <= 1'b0;

      while (book.due_positions.size() != 0) @(posedge clock);
      repeat (QUERY_CYCLES + 12) @(posedge clock);
      if (book.due_positions.size() != 0)
         book.report($sformatf("%0d positions never returned", book.due_positions.size()));

      $display("covered %0d loads (%0d on a full deck) and %0d queries, %0d positions checked",
               book.loads, book.full_loads, book.queries, book.checked);
      $display("final deck count %0d, %0d errors", book.deck_count, book.errors);
      if (book.errors == 0)
         $display("move_to_front_rank_table: match");
      else
         $display("move_to_front_rank_table: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mtfr_pkg.sv
hdl/mtfr_ctrl.sv
hdl/mtfr_dp.sv
hdl/move_to_front_rank_table.sv
tb/testbench.sv
